// ===== rtl/core/hcp_pkg.sv =====
package hcp_pkg;

  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned CODE_W    = 32;
  localparam int unsigned LEN_W     = 6;
  localparam int unsigned SYM_IN_W  = 8;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;

  // One request handed from the table lookup stage to the bit packer.
  typedef struct packed {
    logic              valid;
    logic              flush;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } hcp_lookup_t;

endpackage

// ===== rtl/core/hcp_code_table.sv =====
module hcp_code_table #(
  parameter int unsigned SYMBOL_COUNT = 256,
  parameter int unsigned ADDR_W       = 8
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic [hcp_pkg::CODE_W-1:0] wr_code,
  input  logic [hcp_pkg::LEN_W-1:0]  wr_len,
  input  logic                      rd_en,
  input  logic [ADDR_W-1:0]         rd_addr,
  output logic [hcp_pkg::CODE_W-1:0] rd_code_r,
  output logic [hcp_pkg::LEN_W-1:0]  rd_len_r
);
  import hcp_pkg::*;

  logic [CODE_W-1:0] code_mem [SYMBOL_COUNT];
  logic [LEN_W-1:0]  len_mem  [SYMBOL_COUNT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      code_mem[wr_addr] <= wr_code;
      len_mem[wr_addr]  <= wr_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_code_r <= code_mem[rd_addr];
      rd_len_r  <= len_mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/hcp_bit_packer.sv =====
module hcp_bit_packer #(
  parameter int unsigned MAX_CODE_LENGTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hcp_pkg::hcp_lookup_t req,
  output logic                req_take,
  output logic                out_valid_r,
  input  logic                out_stall,
  output logic [7:0]          out_byte_r,
  output logic                out_final_r
);
  import hcp_pkg::*;

  localparam int unsigned ACC_W = MAX_CODE_LENGTH + BYTE_BITS - 1;
  localparam int unsigned CNT_W = $clog2(ACC_W + 1);
  localparam logic [CNT_W-1:0] BYTE_CNT = CNT_W'(BYTE_BITS);

  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_nxt;
  logic [7:0]       out_byte_nxt;
  logic             out_final_nxt;
  logic             slot_free;
  logic             emit;
  logic [ACC_W-1:0] code_ext;
  logic [ACC_W-1:0] pad_word;
  logic [ACC_W-1:0] byte_word;

  assign slot_free = !out_valid_r || !out_stall;
  assign emit      = (cnt_r >= BYTE_CNT) && slot_free;
  assign req_take  = req.valid && (cnt_r < BYTE_CNT)
                     && (!req.flush || (cnt_r == '0) || slot_free);
  assign code_ext  = ACC_W'(req.code);
  assign byte_word = acc_r >> (cnt_r - BYTE_CNT);
  assign pad_word  = acc_r << (BYTE_CNT - cnt_r);

  always_comb begin
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;
    out_byte_nxt  = out_byte_r;
    out_final_nxt = out_final_r;
    if (emit) begin
      cnt_nxt       = cnt_r - BYTE_CNT;
      out_valid_nxt = 1'b1;
      out_byte_nxt  = byte_word[7:0];
      out_final_nxt = 1'b0;
    end else if (req_take) begin
      if (req.flush) begin
        cnt_nxt = '0;
        if (cnt_r != '0) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = pad_word[7:0];
          out_final_nxt = 1'b1;
        end
      end else begin
        acc_nxt = (acc_r << req.len) | code_ext;
        cnt_nxt = CNT_W'(cnt_r + CNT_W'(req.len));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    acc_r       <= acc_nxt;
    out_byte_r  <= out_byte_nxt;
    out_final_r <= out_final_nxt;
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(ACC_W))
    else $error("pending bit count exceeds accumulator width");

  a_take_low: assert property (@(posedge clk) disable iff (!rst_n)
    req_take |-> (cnt_r < BYTE_CNT) && !emit)
    else $error("request taken while whole bytes still pending");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (req_take && req.flush) |=> (cnt_r == '0))
    else $error("flush left bits pending");

  a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (cnt_r == $past(cnt_r) - BYTE_CNT) && out_valid_r && !out_final_r)
    else $error("byte emission did not consume eight bits");
`endif

endmodule

// ===== rtl/core/huffman_code_packer.sv =====
// Static-table Huffman encoder back end.
// The input channel (in_valid, in_stall) carries three kinds of request.
// A load writes the code word and length of one symbol into the code table.
// An encode looks up the symbol and appends its code to the bit accumulator.
// A flush emits the pending bits, if any, as one zero-padded byte marked final.
// The result channel (out_valid, out_stall) carries one packed byte per
// transfer, earliest bit in the MSB.
// A load only writes the table. An encode passes the table read and the
// append step, then releases its bytes one per cycle while out_stall is low;
// the packer takes no new request until they are out, and the single
// output byte register sets that rate.
// A first byte passes the table read, accumulator and output byte registers.
// While out_stall is high the output byte holds and, once whole bytes back
// up behind it, in_stall rises until the receiver drains them.
// Reset empties the accumulator and the output register; table contents are
// kept and are undefined until loaded.
module huffman_code_packer #(
  parameter int unsigned MAX_CODE_LENGTH = 32,
  parameter int unsigned SYMBOL_COUNT    = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_symbol,
  input  logic [31:0] in_code_bits,
  input  logic [5:0]  in_code_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_packed_byte,
  output logic        out_final_byte
);
  import hcp_pkg::*;

  localparam int unsigned ADDR_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  logic              in_take;
  logic              sym_ok;
  logic [LEN_W-1:0]  len_sat;
  logic [63:0]       len_mask;
  logic [CODE_W-1:0] code_masked;
  logic              tbl_wr;
  logic              tbl_rd;
  logic [CODE_W-1:0] rd_code;
  logic [LEN_W-1:0]  rd_len;
  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_flush_r, s1_flush_nxt;
  logic              s1_take;
  hcp_lookup_t       lookup;

  assign in_stall = s1_valid_r && !s1_take;
  assign in_take  = in_valid && !in_stall;
  assign sym_ok   = {1'b0, in_symbol} < 9'(SYMBOL_COUNT);

  assign len_sat     = (in_code_length > LEN_W'(MAX_CODE_LENGTH))
                       ? LEN_W'(MAX_CODE_LENGTH) : in_code_length;
  assign len_mask    = ~({64{1'b1}} << len_sat);
  assign code_masked = in_code_bits & len_mask[CODE_W-1:0];

  assign tbl_wr = in_take && (in_opcode == OP_LOAD) && sym_ok;
  assign tbl_rd = in_take && (in_opcode == OP_ENCODE) && sym_ok;

  hcp_code_table #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .ADDR_W       (ADDR_W)
  ) u_table (
    .clk       (clk),
    .wr_en     (tbl_wr),
    .wr_addr   (in_symbol[ADDR_W-1:0]),
    .wr_code   (code_masked),
    .wr_len    (len_sat),
    .rd_en     (tbl_rd),
    .rd_addr   (in_symbol[ADDR_W-1:0]),
    .rd_code_r (rd_code),
    .rd_len_r  (rd_len)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r && !s1_take;
    s1_flush_nxt = s1_flush_r;
    if (in_take) begin
      s1_valid_nxt = tbl_rd || (in_opcode == OP_FLUSH);
      s1_flush_nxt = (in_opcode == OP_FLUSH);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    s1_flush_r <= s1_flush_nxt;
  end

  assign lookup.valid = s1_valid_r;
  assign lookup.flush = s1_flush_r;
  assign lookup.code  = rd_code;
  assign lookup.len   = rd_len;

  hcp_bit_packer #(
    .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
  ) u_packer (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (lookup),
    .req_take    (s1_take),
    .out_valid_r (out_valid),
    .out_stall   (out_stall),
    .out_byte_r  (out_packed_byte),
    .out_final_r (out_final_byte)
  );

endmodule

// ===== dv/packed_stream_checker.sv =====
module packed_stream_checker #(
  parameter int unsigned MAX_CODE_LENGTH = 32,
  parameter int unsigned SYMBOL_COUNT    = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_symbol,
  input  logic [31:0] in_code_bits,
  input  logic [5:0]  in_code_length,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_packed_byte,
  input  logic        out_final_byte,
  output int          fail_count,
  output int          expected_left,
  output int          bytes_checked,
  output int          finals_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  import hcp_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } packed_result_t;

  logic [CODE_W-1:0] code_store [SYMBOL_COUNT];
  int unsigned       len_store  [SYMBOL_COUNT];
  logic [63:0]       acc_bits;
  int unsigned       acc_count;
  packed_result_t    expected_bytes [$];
  int                errors;
  int                byte_total;
  int                final_total;

  function automatic logic [63:0] low_bits(input int unsigned n);
    if (n >= 64) begin
      return '1;
    end
    return (64'd1 << n) - 64'd1;
  endfunction

  task automatic predict_packing(input logic [1:0] op, input logic [7:0] sym,
                                 input logic [31:0] bits, input logic [5:0] len);
    int unsigned    clen;
    logic [63:0]    word;
    packed_result_t res;
    case (op)
      OP_LOAD: begin
        if (sym < SYMBOL_COUNT) begin
          clen = (len > MAX_CODE_LENGTH) ? MAX_CODE_LENGTH : len;
          code_store[sym] = CODE_W'(64'(bits) & low_bits(clen));
          len_store[sym] = clen;
        end
      end
      OP_ENCODE: begin
        if (sym < SYMBOL_COUNT && len_store[sym] != 0) begin
          clen = len_store[sym];
          word = ((acc_bits << clen) | (64'(code_store[sym]) & low_bits(clen)))
                 & low_bits(acc_count + clen);
          acc_count += clen;
          while (acc_count >= BYTE_BITS) begin
            acc_count -= BYTE_BITS;
            res.data = 8'(word >> acc_count);
            res.last = 1'b0;
            expected_bytes.push_back(res);
            word &= low_bits(acc_count);
          end
          acc_bits = word;
        end
      end
      OP_FLUSH: begin
        if (acc_count != 0) begin
          res.data = 8'(acc_bits << (BYTE_BITS - acc_count));
          res.last = 1'b1;
          expected_bytes.push_back(res);
          acc_bits = '0;
          acc_count = 0;
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    packed_result_t want;
    if (!rst_n) begin
      acc_bits = '0;
      acc_count = 0;
      expected_bytes.delete();
      errors = 0;
      byte_total = 0;
      final_total = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected result: packed_byte %02h, final_byte %0b",
                 out_packed_byte, out_final_byte);
          errors++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_packed_byte !== want.data) begin
            $error("packed_byte: expected %02h, actual %02h", want.data, out_packed_byte);
            errors++;
          end
          if (out_final_byte !== want.last) begin
            $error("final_byte: expected %0b, actual %0b", want.last, out_final_byte);
            errors++;
          end
          byte_total++;
          if (want.last) begin
            final_total++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_packing(in_opcode, in_symbol, in_code_bits, in_code_length);
      end
    end
    fail_count     <= errors;
    expected_left  <= expected_bytes.size();
    bytes_checked  <= byte_total;
    finals_checked <= final_total;
  end

endmodule

// ===== dv/tb_huffman_code_packer.sv =====
module tb_huffman_code_packer;
  timeunit 1ns;
  timeprecision 1ps;

  import hcp_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_opcode;
  logic [7:0]  in_symbol;
  logic [31:0] in_code_bits;
  logic [5:0]  in_code_length;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_packed_byte;
  logic        out_final_byte;

  int fail_count;
  int expected_left;
  int bytes_checked;
  int finals_checked;

  bit       calm;
  bit       loaded [256];
  bit [7:0] loaded_syms [$];
  int       load_count;
  int       encode_count;
  int       flush_count;
  int       unused_count;

  huffman_code_packer uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_symbol      (in_symbol),
    .in_code_bits   (in_code_bits),
    .in_code_length (in_code_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_packed_byte(out_packed_byte),
    .out_final_byte (out_final_byte)
  );

  packed_stream_checker stream_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_symbol      (in_symbol),
    .in_code_bits   (in_code_bits),
    .in_code_length (in_code_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_packed_byte(out_packed_byte),
    .out_final_byte (out_final_byte),
    .fail_count     (fail_count),
    .expected_left  (expected_left),
    .bytes_checked  (bytes_checked),
    .finals_checked (finals_checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("tb_huffman_code_packer failed");
    $finish;
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      out_stall <= !calm && ($urandom_range(99) < 24);
    end
  end

  task automatic send_request(input logic [1:0] op, input logic [7:0] sym,
                              input logic [31:0] bits, input logic [5:0] len);
    while (!calm && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_symbol      <= sym;
    in_code_bits   <= bits;
    in_code_length <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (op)
      OP_LOAD:   load_count++;
      OP_ENCODE: encode_count++;
      OP_FLUSH:  flush_count++;
      default:   unused_count++;
    endcase
  endtask

  task automatic load_entry(input logic [7:0] sym, input logic [31:0] bits,
                            input logic [5:0] len);
    send_request(OP_LOAD, sym, bits, len);
    if (!loaded[sym]) begin
      loaded[sym] = 1'b1;
      loaded_syms.push_back(sym);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
  endtask

  initial begin
    int          counted;
    int unsigned pick;
    logic [5:0]  len;

    calm           = 1'b0;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_opcode      <= OP_LOAD;
    in_symbol      <= '0;
    in_code_bits   <= '0;
    in_code_length <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_entry(8'd0, 32'hFFFF_FFFF, 6'd32);
    load_entry(8'd255, 32'h0000_0000, 6'd1);
    load_entry(8'd1, 32'h0000_0005, 6'd3);
    load_entry(8'd2, 32'hFFFF_FFFF, 6'd4);
    load_entry(8'd3, 32'hDEAD_BEEF, 6'd0);
    load_entry(8'd4, 32'hA5A5_A5A5, 6'd63);
    load_entry(8'd5, 32'h1234_5678, 6'd33);
    load_entry(8'd6, 32'h8000_0001, 6'd32);
    send_request(OP_FLUSH, 8'd0, 32'h0, 6'd0);
    send_request(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
    send_request(OP_ENCODE, 8'd0, 32'h0, 6'd0);
    send_request(OP_ENCODE, 8'd1, 32'h0, 6'd0);
    send_request(OP_FLUSH, 8'd0, 32'h0, 6'd0);
    send_request(OP_ENCODE, 8'd3, 32'h0, 6'd0);
    send_request(OP_ENCODE, 8'd255, 32'h0, 6'd0);
    send_request(OP_ENCODE, 8'd2, 32'h0, 6'd0);
    send_request(OP_ENCODE, 8'd4, 32'h0, 6'd0);
    send_request(OP_ENCODE, 8'd5, 32'h0, 6'd0);
    send_request(OP_ENCODE, 8'd6, 32'h0, 6'd0);
    send_request(OP_FLUSH, 8'd0, 32'h0, 6'd0);
    send_request(OP_FLUSH, 8'd0, 32'h0, 6'd0);
    load_entry(8'd1, 32'hFFFF_FF6A, 6'd7);
    send_request(OP_ENCODE, 8'd1, 32'h0, 6'd0);
    send_request(OP_ENCODE, 8'd1, 32'h0, 6'd0);
    send_request(OP_FLUSH, 8'd0, 32'h0, 6'd0);
    drain_results();

    counted = 0;
    while (counted < 70) begin
      if (counted == 35) begin
        drain_results();
      end
      calm = (counted >= 40 && counted < 65);
      pick = $urandom_range(99);
      if (pick < 22) begin
        pick = $urandom_range(99);
        if (pick < 5) begin
          len = 6'd0;
        end else if (pick < 12) begin
          len = 6'($urandom_range(63, 33));
        end else if (pick < 40) begin
          len = 6'($urandom_range(32, 17));
        end else begin
          len = 6'($urandom_range(16, 1));
        end
        load_entry(8'($urandom_range(255)), $urandom(), len);
        counted++;
      end else if (pick < 82) begin
        send_request(OP_ENCODE, loaded_syms[$urandom_range(loaded_syms.size() - 1)],
                     $urandom(), 6'($urandom_range(63)));
        counted++;
      end else if (pick < 95) begin
        send_request(OP_FLUSH, 8'($urandom_range(255)), $urandom(),
                     6'($urandom_range(63)));
        counted++;
      end else begin
        send_request(OP_UNUSED, 8'($urandom_range(255)), $urandom(),
                     6'($urandom_range(63)));
      end
    end
    calm = 1'b0;
    drain_results();
    repeat (20) @(posedge clk);

    $display("Sent %0d loads, %0d encodes, %0d flushes and %0d unused-opcode requests.",
             load_count, encode_count, flush_count, unused_count);
    $display("Compared %0d packed bytes, %0d of them final padded bytes.",
             bytes_checked, finals_checked);
    if (fail_count == 0 && expected_left == 0) begin
      $display("tb_huffman_code_packer passed");
    end else begin
      $display("tb_huffman_code_packer failed");
    end
    $finish;
  end

endmodule
